// ===== hw/rtl/dst_change_tracker_macros.svh =====
// Assertion macros for the DST change tracker.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef DST_CHANGE_TRACKER_MACROS_SVH
`define DST_CHANGE_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
// plain property, checked out of reset
`define DCT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition in one cycle implies a consequence in the next
`define DCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define DCT_ASSERT(lbl, clk, rstn, prop, msg)
`define DCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/dct_pkg.sv =====
// Shared types, constants and calendar helpers for the DST change tracker.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package dct_pkg;

  localparam int unsigned YEAR_W = 12;
  typedef logic [YEAR_W-1:0] year_t;

  // op codes
  localparam logic OP_RESYNC = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // change codes
  localparam logic [1:0] CHG_NONE = 2'd0;
  localparam logic [1:0] CHG_RISE = 2'd1;
  localparam logic [1:0] CHG_FALL = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_REF_START = 2'd0;
  localparam logic [1:0] CFG_REF_END   = 2'd1;
  localparam logic [1:0] CFG_DST_OFF   = 2'd2;
  localparam logic [1:0] CFG_STD_OFF   = 2'd3;

  localparam logic [31:0] SEC_364D   = 32'd31449600;
  localparam logic [31:0] SEC_7D     = 32'd604800;
  localparam logic [31:0] SEC_YEAR   = 32'd31536000;
  localparam logic [31:0] SEC_LEAP   = 32'd31622400;
  localparam logic [31:0] TIME_MAX   = 32'hFFFF_FFFF;

  localparam year_t YEAR_EPOCH   = 12'd1970;
  localparam year_t YEAR_CENTURY = 12'd2100;
  localparam year_t BIAS_LO      = 12'd16;
  localparam year_t BIAS_HI      = 12'd22;

  localparam logic [14:0] WEEK_MOD  = 15'd56;
  localparam logic [14:0] WEEK_WIN  = 15'd10;
  // floor(2^16/56); estimate is exact or one low for 10*B below 2^15
  localparam logic [25:0] WEEK_RECIP = 26'd1170;

  localparam logic [31:0] RST_START = 32'd1489284000;
  localparam logic [31:0] RST_END   = 32'd1478397600;
  localparam logic signed [16:0] RST_DST_OFF = -17'sd14400;
  localparam logic signed [16:0] RST_STD_OFF = -17'sd18000;

  typedef struct packed {
    logic load_item;
    logic sel_end;
    logic set_rise;
    logic set_fall;
    logic set_sync_off;
    logic set_flag;
    logic adv_init;
    logic year_step;
    logic adv_finish;
    logic load_out;
  } dct_cmd_t;

  typedef struct packed {
    logic op;
    logic ge_start;
    logic ge_end;
    logic ge_sel;
    logic year_found;
  } dct_stat_t;

  // 32-bit UTC seconds only reach 2106: 2100 is the one non-leap century year in range
  function automatic logic is_leap(input year_t year);
    return (year[1:0] == 2'b00) && (year != YEAR_CENTURY);
  endfunction

  function automatic logic [31:0] year_secs(input year_t year);
    return is_leap(year) ? SEC_LEAP : SEC_YEAR;
  endfunction

  // extra week when a multiple of 56 falls in (10*B - 10, 10*B]
  function automatic logic week_due(input year_t year);
    year_t       b;
    logic [14:0] x;
    logic [25:0] prod;
    logic [8:0]  q;
    logic [14:0] r;
    b    = (year < YEAR_CENTURY) ? year - BIAS_LO : year - BIAS_HI;
    x    = (15'(b) << 3) + (15'(b) << 1);
    prod = 26'(x) * WEEK_RECIP;
    q    = prod[24:16];
    r    = x - ((15'(q) << 6) - (15'(q) << 3));
    if (r >= WEEK_MOD) begin
      r = r - WEEK_MOD;
    end
    return r < WEEK_WIN;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dst_change_tracker.sv =====
// A tick with no change goes straight to its result; a tick that fires advances one
// instant. A resync advances each instant until it passes the current time, up to
// 2*MAX_ADVANCES advances in all. An advance walks the years up from 1970 to the year
// reached (at most 2106), one year subtracted per cycle.
// One item at a time; a new item is accepted while the previous result waits to be taken.
// Async active-low reset restores reference instants, reset offsets and zero current offset.
`default_nettype none

module dst_change_tracker import dct_pkg::*; #(
  parameter int unsigned MAX_ADVANCES = 255
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               op_i,
  input  wire logic [31:0]        current_time_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              change_o,
  output logic signed [16:0]      utc_offset_o,
  output logic [31:0]             next_start_o,
  output logic [31:0]             next_end_o,
  output logic                    limit_hit_o
);

  dct_cmd_t  cmd;
  dct_stat_t stat;

  dct_ctrl #(
    .MAX_ADVANCES (MAX_ADVANCES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dct_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (op_i),
    .current_time_i (current_time_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .change_o       (change_o),
    .utc_offset_o   (utc_offset_o),
    .next_start_o   (next_start_o),
    .next_end_o     (next_end_o),
    .limit_hit_o    (limit_hit_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/dct_datapath.sv =====
// Datapath: tracked instants, offsets, the advance unit (year walk) and result registers.
// Depends on dct_pkg; driven by dct_ctrl through dct_cmd_t, reports dct_stat_t.
`default_nettype none

module dct_datapath import dct_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               op_i,
  input  wire logic [31:0]        current_time_i,
  input  wire dct_cmd_t           cmd_i,
  output dct_stat_t               stat_o,
  output logic [1:0]              change_o,
  output logic signed [16:0]      utc_offset_o,
  output logic [31:0]             next_start_o,
  output logic [31:0]             next_end_o,
  output logic                    limit_hit_o
);

  logic [31:0]        start_q, start_d;
  logic [31:0]        end_q, end_d;
  logic signed [16:0] offset_q, offset_d;
  logic signed [16:0] dst_off_q, dst_off_d;
  logic signed [16:0] std_off_q, std_off_d;

  logic [31:0] now_q, now_d;
  logic        op_q, op_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] rem_q, rem_d;
  year_t       year_q, year_d;
  logic        flag_q, flag_d;
  logic [1:0]  chg_q, chg_d;

  logic [31:0] inst;
  logic [32:0] sum_init;
  logic [32:0] sum_week;
  logic [31:0] ylen;
  logic [31:0] adv_res;

  assign inst     = cmd_i.sel_end ? end_q : start_q;
  assign ylen     = year_secs(year_q);
  assign sum_init = {1'b0, inst} + {1'b0, SEC_364D};
  assign sum_week = {1'b0, acc_q} + {1'b0, SEC_7D};
  assign adv_res  = week_due(year_q) ? (sum_week[32] ? TIME_MAX : sum_week[31:0]) : acc_q;

  assign stat_o.op         = op_q;
  assign stat_o.ge_start   = now_q >= start_q;
  assign stat_o.ge_end     = now_q >= end_q;
  assign stat_o.ge_sel     = now_q >= inst;
  assign stat_o.year_found = rem_q < ylen;

  always_comb begin
    start_d   = start_q;
    end_d     = end_q;
    offset_d  = offset_q;
    dst_off_d = dst_off_q;
    std_off_d = std_off_q;
    now_d     = now_q;
    op_d      = op_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    year_d    = year_q;
    flag_d    = flag_q;
    chg_d     = chg_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REF_START: start_d   = cfg_wdata_i;
        CFG_REF_END:   end_d     = cfg_wdata_i;
        CFG_DST_OFF:   dst_off_d = cfg_wdata_i[16:0];
        CFG_STD_OFF:   std_off_d = cfg_wdata_i[16:0];
        default: ;
      endcase
    end

    if (cmd_i.load_item) begin
      now_d  = current_time_i;
      op_d   = op_i;
      flag_d = 1'b0;
      chg_d  = CHG_NONE;
    end
    if (cmd_i.set_rise) begin
      chg_d    = CHG_RISE;
      offset_d = dst_off_q;
    end
    if (cmd_i.set_fall) begin
      chg_d    = CHG_FALL;
      offset_d = std_off_q;
    end
    if (cmd_i.set_sync_off) begin
      offset_d = (start_q >= end_q) ? dst_off_q : std_off_q;
    end
    if (cmd_i.set_flag) begin
      flag_d = 1'b1;
    end
    if (cmd_i.adv_init) begin
      acc_d  = sum_init[32] ? TIME_MAX : sum_init[31:0];
      rem_d  = sum_init[32] ? TIME_MAX : sum_init[31:0];
      year_d = YEAR_EPOCH;
      if (sum_init[32] || (inst == TIME_MAX)) begin
        flag_d = 1'b1;
      end
    end
    if (cmd_i.year_step) begin
      rem_d  = rem_q - ylen;
      year_d = year_q + 1'b1;
    end
    if (cmd_i.adv_finish) begin
      if (week_due(year_q) && sum_week[32]) begin
        flag_d = 1'b1;
      end
      if (cmd_i.sel_end) begin
        end_d = adv_res;
      end else begin
        start_d = adv_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= RST_START;
      end_q     <= RST_END;
      offset_q  <= '0;
      dst_off_q <= RST_DST_OFF;
      std_off_q <= RST_STD_OFF;
    end else begin
      start_q   <= start_d;
      end_q     <= end_d;
      offset_q  <= offset_d;
      dst_off_q <= dst_off_d;
      std_off_q <= std_off_d;
    end
  end

  // working and result registers, qualified by controller state
  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    op_q   <= op_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    year_q <= year_d;
    flag_q <= flag_d;
    chg_q  <= chg_d;
    if (cmd_i.load_out) begin
      change_o     <= chg_q;
      utc_offset_o <= offset_q;
      next_start_o <= start_q;
      next_end_o   <= end_q;
      limit_hit_o  <= flag_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dct_ctrl.sv =====
// Controller FSM: sequences tick/resync handling, advance counts and the result beat.
// Depends on dct_pkg and dst_change_tracker_macros.svh; commands dct_datapath.
`default_nettype none
`include "dst_change_tracker_macros.svh"

module dct_ctrl import dct_pkg::*; #(
  parameter int unsigned MAX_ADVANCES = 255
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire dct_stat_t stat_i,
  output dct_cmd_t       cmd_o
);

  localparam int unsigned CntW = $clog2(MAX_ADVANCES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ADVANCES);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_RS_CHK   = 3'd2;
  localparam logic [2:0] S_ADV_INIT = 3'd3;
  localparam logic [2:0] S_YEAR     = 3'd4;
  localparam logic [2:0] S_WEEK     = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  logic [2:0]      state_q, state_d;
  logic            sel_q, sel_d;
  logic [CntW-1:0] n_q, n_d;
  logic            out_valid_q, out_valid_d;

  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.sel_end = sel_q;
    state_d       = state_q;
    sel_d         = sel_q;
    n_d           = n_q;
    in_ready_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.op == OP_TICK) begin
          priority if (stat_i.ge_start) begin
            cmd_o.set_rise = 1'b1;
            sel_d          = 1'b0;
            state_d        = S_ADV_INIT;
          end else if (stat_i.ge_end) begin
            cmd_o.set_fall = 1'b1;
            sel_d          = 1'b1;
            state_d        = S_ADV_INIT;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          sel_d   = 1'b0;
          n_d     = '0;
          state_d = S_RS_CHK;
        end
      end
      S_RS_CHK: begin
        if (stat_i.ge_sel && (n_q < CntMax)) begin
          n_d     = n_q + 1'b1;
          state_d = S_ADV_INIT;
        end else begin
          cmd_o.set_flag = stat_i.ge_sel;
          if (!sel_q) begin
            sel_d = 1'b1;
            n_d   = '0;
          end else begin
            cmd_o.set_sync_off = 1'b1;
            state_d            = S_FIN;
          end
        end
      end
      S_ADV_INIT: begin
        cmd_o.adv_init = 1'b1;
        state_d        = S_YEAR;
      end
      S_YEAR: begin
        if (stat_i.year_found) begin
          state_d = S_WEEK;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      S_WEEK: begin
        cmd_o.adv_finish = 1'b1;
        state_d          = (stat_i.op == OP_TICK) ? S_FIN : S_RS_CHK;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  `DCT_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_DISPATCH, "accepted beat did not start processing")
  `DCT_ASSERT(a_cnt_bound, clk_i, rst_ni, n_q <= CntMax, "advance count beyond limit")
  `DCT_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd_o.load_out |-> (!out_valid_q || out_ready_i), "result overwritten before taken")
  `DCT_ASSERT_NEXT(a_year_exit, clk_i, rst_ni, state_q == S_YEAR, state_q == S_YEAR || state_q == S_WEEK, "year walk left early")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for dst_change_tracker: directed and random beats,
// predicted by an in-bench model of the start/end instant tracking.
// Depends on dct_pkg and the dst_change_tracker RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dct_pkg::*;

  localparam int unsigned ADV_LIMIT = 255;
  localparam int unsigned SECS_DAY  = 86400;

  typedef struct packed {
    logic [1:0]         change;
    logic signed [16:0] offset;
    logic [31:0]        start_at;
    logic [31:0]        end_at;
    logic               limit;
  } dst_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [31:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               op_i;
  logic [31:0]        current_time_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         change_o;
  logic signed [16:0] utc_offset_o;
  logic [31:0]        next_start_o;
  logic [31:0]        next_end_o;
  logic               limit_hit_o;

  // tracker state as the bench expects it
  logic [31:0]        trk_start;
  logic [31:0]        trk_end;
  logic signed [16:0] cur_offset;
  logic signed [16:0] dst_offset;
  logic signed [16:0] std_offset;
  logic               adv_sat;

  dst_result_t        pending_results[$];
  dst_result_t        want;
  int unsigned        error_count = 0;
  int unsigned        send_idle_pct = 28;
  int unsigned        recv_idle_pct = 69;

  dst_change_tracker #(.MAX_ADVANCES(ADV_LIMIT)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .current_time_i (current_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .change_o       (change_o),
    .utc_offset_o   (utc_offset_o),
    .next_start_o   (next_start_o),
    .next_end_o     (next_end_o),
    .limit_hit_o    (limit_hit_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model
  function automatic int unsigned days_in_year(input int unsigned yr);
    return ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) ? 366 : 365;
  endfunction

  function automatic int unsigned calendar_year(input logic [31:0] t);
    int unsigned days;
    int unsigned yr;
    days = t / SECS_DAY;
    yr   = 1970;
    while (days >= days_in_year(yr)) begin
      days = days - days_in_year(yr);
      yr++;
    end
    return yr;
  endfunction

  function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum[32]) begin
      adv_sat = 1'b1;
      return TIME_MAX;
    end
    return sum[31:0];
  endfunction

  // one year forward, plus a leap week when the 10/56 rule says so
  function automatic logic [31:0] next_instant(input logic [31:0] t);
    logic        at_max;
    int unsigned yr;
    int unsigned base;
    at_max = (t == TIME_MAX);
    t      = add_clamped(t, SEC_364D);
    yr     = calendar_year(t);
    base   = (yr < int'(YEAR_CENTURY)) ? yr - int'(BIAS_LO) : yr - int'(BIAS_HI);
    if ((base * 10) / 56 != (base * 10 - 10) / 56) begin
      t = add_clamped(t, SEC_7D);
    end
    if (at_max) begin
      adv_sat = 1'b1;
    end
    return t;
  endfunction

  function automatic dst_result_t predict_beat(input logic op, input logic [31:0] now);
    dst_result_t r;
    int unsigned n;
    r.change = CHG_NONE;
    adv_sat  = 1'b0;
    if (op == OP_RESYNC) begin
      n = 0;
      while (now >= trk_start && n < ADV_LIMIT) begin
        trk_start = next_instant(trk_start);
        n++;
      end
      if (now >= trk_start) begin
        adv_sat = 1'b1;
      end
      n = 0;
      while (now >= trk_end && n < ADV_LIMIT) begin
        trk_end = next_instant(trk_end);
        n++;
      end
      if (now >= trk_end) begin
        adv_sat = 1'b1;
      end
      cur_offset = (trk_start >= trk_end) ? dst_offset : std_offset;
    end else if (now >= trk_start) begin
      r.change   = CHG_RISE;
      cur_offset = dst_offset;
      trk_start  = next_instant(trk_start);
    end else if (now >= trk_end) begin
      r.change   = CHG_FALL;
      cur_offset = std_offset;
      trk_end    = next_instant(trk_end);
    end
    r.offset   = cur_offset;
    r.start_at = trk_start;
    r.end_at   = trk_end;
    r.limit    = adv_sat;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_beat(input logic op, input logic [31:0] now);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    current_time_i <= now;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    pending_results.push_back(predict_beat(op, now));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_REF_START: trk_start  = data;
      CFG_REF_END:   trk_end    = data;
      CFG_DST_OFF:   dst_offset = data[16:0];
      CFG_STD_OFF:   std_offset = data[16:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offsets go out with junk in the unused upper bits
  task automatic program_regs(input logic [31:0] start_t, input logic [31:0] end_t,
                              input logic signed [16:0] dst, input logic signed [16:0] std);
    wait_idle();
    write_reg(CFG_REF_START, start_t);
    write_reg(CFG_REF_END, end_t);
    write_reg(CFG_DST_OFF, {15'($urandom()), 17'(dst)});
    write_reg(CFG_STD_OFF, {15'($urandom()), 17'(std)});
  endtask

  function automatic logic [31:0] clamp_time(input longint v);
    if (v < 0) begin
      return 32'd0;
    end
    if (v > longint'(TIME_MAX)) begin
      return TIME_MAX;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] rand_instant();
    return $urandom_range(32'd2209000000, 32'd1420070400);
  endfunction

  function automatic logic signed [16:0] rand_offset();
    case ($urandom_range(9))
      0:       return 17'sd50400;
      1:       return -17'sd50400;
      2:       return 17'($urandom());
      default: return 17'($urandom_range(100800)) - 17'sd50400;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic note_error(input string what, input logic [31:0] exp_v,
                            input logic [31:0] got_v);
    if (error_count < 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, got_v);
    end
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_error("unexpected beat", 32'd0, next_start_o);
      end else begin
        want = pending_results.pop_front();
        if (change_o !== want.change) begin
          note_error("change", 32'(want.change), 32'(change_o));
        end
        if (utc_offset_o !== want.offset) begin
          note_error("utc_offset", 32'(want.offset), 32'(utc_offset_o));
        end
        if (next_start_o !== want.start_at) begin
          note_error("next_start", want.start_at, next_start_o);
        end
        if (next_end_o !== want.end_at) begin
          note_error("next_end", want.end_at, next_end_o);
        end
        if (limit_hit_o !== want.limit) begin
          note_error("limit_hit", 32'(want.limit), 32'(limit_hit_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_reset_state();
    send_beat(OP_TICK, 32'd0);
    send_beat(OP_TICK, RST_END);
    send_beat(OP_RESYNC, RST_START);
  endtask

  // exact hits, one second short, and both instants passed at once
  task automatic test_tick_edges();
    program_regs(32'd1520000000, 32'd1540000000, RST_DST_OFF, RST_STD_OFF);
    send_beat(OP_TICK, 32'd1519999999);
    send_beat(OP_TICK, 32'd1520000000);
    send_beat(OP_TICK, 32'd1539999999);
    send_beat(OP_TICK, 32'd1540000000);
    send_beat(OP_TICK, TIME_MAX);
  endtask

  // end advances into 2099, start into 2100 where the year bias changes
  task automatic test_century_rule();
    program_regs(32'd4100000000, 32'd4060000000, RST_DST_OFF, RST_STD_OFF);
    send_beat(OP_TICK, 32'd4060000000);
    send_beat(OP_TICK, 32'd4100000000);
  endtask

  task automatic test_saturation();
    program_regs(32'hFFFF_FF00, TIME_MAX, RST_DST_OFF, RST_STD_OFF);
    send_beat(OP_TICK, 32'hFFFF_FF00);
    send_beat(OP_TICK, TIME_MAX);
    send_beat(OP_TICK, 32'hFFFF_FFFE);
  endtask

  task automatic test_resync_limit();
    program_regs(32'd0, 32'd0, RST_DST_OFF, RST_STD_OFF);
    send_beat(OP_RESYNC, TIME_MAX);
    send_beat(OP_RESYNC, 32'd0);
    program_regs(RST_START, RST_END, 17'sd3600, -17'sd3600);
    send_beat(OP_RESYNC, 32'd1500000000);
  endtask

  task automatic test_offset_range();
    program_regs(32'd1600000000, 32'd1610000000, 17'sd50400, -17'sd50400);
    send_beat(OP_TICK, 32'd1600000000);
    send_beat(OP_TICK, 32'd1610000000);
    program_regs(32'd1600000000, 32'd1610000000, 17'sh10000, 17'sh0FFFF);
    send_beat(OP_TICK, 32'd1600000000);
    send_beat(OP_TICK, 32'd1610000000);
  endtask

  // mostly ticks around the next instant so changes keep firing, some resyncs
  task automatic test_random_traffic(input int unsigned count);
    logic [31:0] soonest;
    longint      pick;
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      soonest = (trk_start < trk_end) ? trk_start : trk_end;
      roll    = $urandom_range(99);
      if (roll < 60) begin
        pick = longint'(soonest) + longint'($urandom_range(7200)) - 3600;
        if ($urandom_range(9) == 0) begin
          pick = longint'(soonest);
        end
        send_beat(OP_TICK, clamp_time(pick));
      end else if (roll < 75) begin
        pick = longint'(soonest) - longint'($urandom_range(200 * SECS_DAY));
        send_beat(OP_TICK, clamp_time(pick));
      end else if (roll < 88 && soonest != TIME_MAX) begin
        pick = longint'(soonest) + longint'($urandom_range(2 * 365 * SECS_DAY));
        send_beat(OP_RESYNC, clamp_time(pick));
      end else if (roll < 96) begin
        pick = longint'(soonest) - longint'($urandom_range(365 * SECS_DAY));
        send_beat(OP_RESYNC, clamp_time(pick));
      end else if (roll < 99) begin
        send_beat(OP_TICK, $urandom());
      end else begin
        send_beat(OP_RESYNC, $urandom());
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_REF_START;
    cfg_wdata_i    = 32'd0;
    in_valid_i     = 1'b0;
    op_i           = OP_TICK;
    current_time_i = 32'd0;
    out_ready_i    = 1'b0;
    trk_start      = RST_START;
    trk_end        = RST_END;
    cur_offset     = 17'sd0;
    dst_offset     = RST_DST_OFF;
    std_offset     = RST_STD_OFF;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_tick_edges();
    test_century_rule();
    test_saturation();
    test_resync_limit();
    test_offset_range();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 3; s++) begin
        program_regs(rand_instant(), rand_instant(), rand_offset(), rand_offset());
        test_random_traffic(167);
      end
    end

    wait_idle();
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #240_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
